// ===== sv/psg_pkg.sv =====
`timescale 1ns / 1ps

package psg_pkg;

  // Fixed field widths of the command and point items.
  localparam int OP_W     = 1;
  localparam int ANGLE_W  = 12;
  localparam int RADIUS_W = 7;
  localparam int COORD_W  = 8;

  // Configuration register widths, indexes and reset values.
  localparam int RSTEP_W    = 5;
  localparam int ASTEP_W    = 8;
  localparam int OFFSET_W   = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 2'd2;

  localparam logic [RSTEP_W-1:0]  RADIAL_STEP_RST   = 5'd5;
  localparam logic [ASTEP_W-1:0]  ARC_STEP_RST      = 8'd20;
  localparam logic [OFFSET_W-1:0] CENTER_OFFSET_RST = 8'd125;

  // Stroke kinds.
  localparam logic [OP_W-1:0] OP_RADIAL = 1'b0;
  localparam logic [OP_W-1:0] OP_ARC    = 1'b1;

  // Default structural parameters.
  localparam int ANGLE_BITS_DEF     = 12;
  localparam int MAX_POINTS_DEF     = 64;
  localparam int SINE_FRAC_BITS_DEF = 14;

  // pi/2 in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // One quarter-wave sine entry, built by an integer Taylor series in Q30
  // and rounded to nearest. Evaluated only while the design elaborates.
  // Term n is the previous term times x^2 divided by (2n)(2n+1); once a term
  // reaches zero every later term is zero as well.
  function automatic logic [31:0] sine_entry(int unsigned k, int unsigned angle_bits,
                                             int unsigned frac_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned quarter;
    longint unsigned rounded;
    longint          sum;
    quarter = 64'd1 << (angle_bits - 2);
    x       = (HALF_PI_Q30 * k) >> (angle_bits - 2);
    x2      = (x * x) >> 30;
    term    = x;
    sum     = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd506;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd600;
    sum  = sum + longint'(term);
    if (sum < 0)
      sum = 0;
    if (sum > (longint'(1) << 30))
      sum = longint'(1) << 30;
    rounded = ((unsigned'(sum) << frac_bits) + (64'd1 << 29)) >> 30;
    if (k == 0)
      rounded = 0;
    if (64'(k) == quarter)
      rounded = 64'd1 << frac_bits;
    return rounded[31:0];
  endfunction

endpackage

// ===== sv/psg_if.sv =====
`timescale 1ns / 1ps

// Stroke command channel.
interface psg_cmd_if;
  import psg_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ANGLE_W-1:0]  angle_start;
  logic [ANGLE_W-1:0]  angle_end;
  logic [RADIUS_W-1:0] radius_start;
  logic [RADIUS_W-1:0] radius_end;

  modport source (
    output valid, op, angle_start, angle_end, radius_start, radius_end,
    input  ready
  );
  modport sink (
    input  valid, op, angle_start, angle_end, radius_start, radius_end,
    output ready
  );
endinterface

// Display point channel.
interface psg_pt_if;
  import psg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               last;

  modport source (
    output valid, x_coord, y_coord, last,
    input  ready
  );
  modport sink (
    input  valid, x_coord, y_coord, last,
    output ready
  );
endinterface

// ===== sv/polar_stroke_point_generator_core.sv =====
`timescale 1ns / 1ps

// Polar stroke point generator for a vector (XY) display.
//
// The cmd channel takes one stroke command per item: a radial line at a fixed
// angle, or an arc at a fixed radius. The pt channel returns the display points
// of that stroke, one item each, with last set on the final point. A stroke
// whose endpoints are equal produces no points and leaves the sequencer idle. At
// most MAX_POINTS points are produced per stroke.
//
// Every point passes through the states LO, HI, MULHI and EMIT: two reads of
// the shared sine table port (sine and cosine entry) and the one shared
// multiplier, then the point is placed in the output register. cmd.ready is
// high only between strokes, so a new stroke is taken only after the last
// point of the previous one. A stalled receiver holds the pending point in the
// output register and the sequencer waits; nothing is dropped.
// The configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them between strokes; the block does not enforce this.
// Reset is synchronous: it empties the output register, returns the sequencer
// to idle and loads the register defaults.
module polar_stroke_point_generator_core #(
  parameter int ANGLE_BITS     = psg_pkg::ANGLE_BITS_DEF,
  parameter int MAX_POINTS     = psg_pkg::MAX_POINTS_DEF,
  parameter int SINE_FRAC_BITS = psg_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0] cfg_data,
  psg_cmd_if.sink                        cmd,
  psg_pt_if.source                       pt
);
  import psg_pkg::*;

  localparam int AB   = ANGLE_BITS;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int PW   = RADIUS_W + SINE_FRAC_BITS + 1;
  localparam logic [AB-2:0] QTR = (AB - 1)'(1) << (AB - 2);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LO    = 3'd1;
  localparam logic [2:0] ST_HI    = 3'd2;
  localparam logic [2:0] ST_MULHI = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // Place a signed magnitude around the center and saturate to the display.
  function automatic logic [COORD_W-1:0] place(logic [RADIUS_W-1:0] m, logic neg,
                                               logic [OFFSET_W-1:0] off);
    logic [COORD_W:0] s;
    s = {1'b0, off} + (COORD_W + 1)'(m);
    if (neg) begin
      if (COORD_W'(m) > off)
        return '0;
      else
        return off - COORD_W'(m);
    end
    if (s[COORD_W])
      return '1;
    return s[COORD_W-1:0];
  endfunction

  // Configuration registers.
  logic [RSTEP_W-1:0]  radial_step;
  logic [ASTEP_W-1:0]  arc_step;
  logic [OFFSET_W-1:0] center_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      radial_step   <= RADIAL_STEP_RST;
      arc_step      <= ARC_STEP_RST;
      center_offset <= CENTER_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIAL_STEP:   radial_step   <= cfg_data[RSTEP_W-1:0];
        REG_ARC_STEP:      arc_step      <= cfg_data[ASTEP_W-1:0];
        REG_CENTER_OFFSET: center_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero step behaves as a step of one.
  logic [RSTEP_W-1:0] rstep_eff;
  logic [ASTEP_W-1:0] astep_eff;
  assign rstep_eff = (radial_step == '0) ? RSTEP_W'(1) : radial_step;
  assign astep_eff = (arc_step == '0) ? ASTEP_W'(1) : arc_step;

  // Stroke context, latched when a command is accepted.
  logic [2:0]          state;
  logic [OP_W-1:0]     op_r;
  logic                up;
  logic [RADIUS_W-1:0] r_end;
  logic [AB-1:0]       a_base;
  logic [AB-1:0]       span;
  logic [RADIUS_W-1:0] cur_r;
  logic [AB-1:0]       cur_ang;
  logic [AB:0]         t;
  logic [CW-1:0]       cnt;
  logic [RADIUS_W-1:0] mag_lo;
  logic [RADIUS_W-1:0] mag_hi;

  // Command fields at the angle resolution of the table.
  logic [AB-1:0] a1m;
  logic [AB-1:0] a2m;
  logic          empty;
  assign a1m   = AB'(cmd.angle_start);
  assign a2m   = AB'(cmd.angle_end);
  assign empty = (cmd.op == OP_RADIAL) ? (cmd.radius_start == cmd.radius_end) : (a1m == a2m);

  assign cmd.ready = (state == ST_IDLE);

  // Table address: the sine entry first, then its complement for the cosine.
  logic [1:0]              quad;
  logic [AB-3:0]           idx;
  logic [AB-2:0]           rom_addr;
  logic [SINE_FRAC_BITS:0] rom_data;
  assign quad     = cur_ang[AB-1:AB-2];
  assign idx      = cur_ang[AB-3:0];
  assign rom_addr = (state == ST_HI) ? (QTR - {1'b0, idx}) : {1'b0, idx};

  psg_sine_rom #(
    .ANGLE_BITS     (ANGLE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // The shared multiplier: radius times table entry, magnitude truncated.
  logic [PW-1:0]       prod;
  logic [RADIUS_W-1:0] mag;
  assign prod = PW'(cur_r) * PW'(rom_data);
  assign mag  = prod[SINE_FRAC_BITS +: RADIUS_W];

  // Next point of the stroke and whether it exists.
  logic [RADIUS_W+1:0] nr;
  logic [AB:0]         nt;
  logic [CW-1:0]       cnt_next;
  logic                cont;
  logic                more;
  logic                out_free;

  always_comb begin
    nr = up ? ((RADIUS_W + 2)'(cur_r) + (RADIUS_W + 2)'(rstep_eff))
            : ((RADIUS_W + 2)'(cur_r) - (RADIUS_W + 2)'(rstep_eff));
    nt = t + (AB + 1)'(astep_eff);
    if (op_r == OP_RADIAL) begin
      if (up)
        cont = nr < (RADIUS_W + 2)'(r_end);
      else
        cont = !nr[RADIUS_W+1] && (nr > (RADIUS_W + 2)'(r_end));
    end else begin
      cont = nt < {1'b0, span};
    end
    cnt_next = cnt + CW'(1);
    more     = (cnt_next < CW'(MAX_POINTS)) && cont;
  end

  assign out_free = !pt.valid || pt.ready;

  // Quadrant mapping of the two magnitudes onto x and y.
  logic [RADIUS_W-1:0] mx;
  logic [RADIUS_W-1:0] my;
  assign mx = quad[0] ? mag_hi : mag_lo;
  assign my = quad[0] ? mag_lo : mag_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pt.valid <= 1'b0;
    end else begin
      // A new point fills the output register; otherwise an accepted point
      // leaves it empty.
      if (state == ST_EMIT && out_free)
        pt.valid <= 1'b1;
      else if (pt.ready)
        pt.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid && !empty)
            state <= ST_LO;
        end
        ST_LO:    state <= ST_HI;
        ST_HI:    state <= ST_MULHI;
        ST_MULHI: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free)
            state <= more ? ST_LO : ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op_r    <= cmd.op;
        up      <= cmd.radius_end > cmd.radius_start;
        r_end   <= cmd.radius_end;
        a_base  <= a1m;
        span    <= a2m - a1m;
        cur_r   <= cmd.radius_start;
        cur_ang <= a1m;
        t       <= '0;
        cnt     <= '0;
      end
      ST_HI:    mag_lo <= mag;
      ST_MULHI: mag_hi <= mag;
      ST_EMIT: begin
        if (out_free) begin
          pt.x_coord <= place(mx, quad[1], center_offset);
          pt.y_coord <= place(my, quad[1] ^ quad[0], center_offset);
          pt.last    <= !more;
          cnt        <= cnt_next;
          if (op_r == OP_RADIAL) begin
            cur_r <= nr[RADIUS_W-1:0];
          end else begin
            t       <= nt;
            cur_ang <= a_base + nt[AB-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/psg_sine_rom.sv =====
`timescale 1ns / 1ps

// Quarter-wave sine table, entries 0..2^(ANGLE_BITS-2) inclusive, with a registered read.
module psg_sine_rom #(
  parameter int ANGLE_BITS     = 12,
  parameter int SINE_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic [ANGLE_BITS-2:0]   addr,
  output logic [SINE_FRAC_BITS:0] data
);
  import psg_pkg::*;

  localparam int DEPTH = (1 << (ANGLE_BITS - 2)) + 1;

  logic [SINE_FRAC_BITS:0] tab [0:DEPTH-1];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    assign tab[k] = (SINE_FRAC_BITS + 1)'(sine_entry(k, ANGLE_BITS, SINE_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule
